/* hw/rtl/imh_pkg.sv */
// shared types and codes for the indexed max-heap unit
package imh_pkg;

    localparam int FUNC_BITS   = 2;
    localparam int STATUS_BITS = 3;

    typedef enum logic [1:0] {
        FN_PUSH     = 2'd0,
        FN_POP      = 2'd1,
        FN_REMOVE   = 2'd2,
        FN_CONTAINS = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_FULL      = 3'd2,
        ST_DUPLICATE = 3'd3,
        ST_ABSENT    = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_LOOKUP,
        S_DECIDE,
        S_MOVE,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RD,
        S_DN_RD2,
        S_LOOKUP_CHILD,
        S_RIGHT,
        S_DN_CMP,
        S_TOP_RD,
        S_TOP_WAIT,
        S_DONE
    } t_state;

endpackage

/* hw/rtl/imh_ram.sv */
// generic single-port-write, one-read ram with registered read data
module imh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* hw/rtl/imh_front.sv */
// front end: request queue between the input port and the heap engine
module imh_front #(
    parameter int KEY_BITS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    output logic                         o_full,
    input  logic [imh_pkg::FUNC_BITS-1:0] i_func,
    input  logic signed [KEY_BITS-1:0]   i_key,
    output logic                         o_valid,
    output imh_pkg::t_func               o_func,
    output logic [KEY_BITS-1:0]          o_key,
    input  logic                         i_take
);

    localparam int DEPTH = 2;

    imh_pkg::t_func      r_func [DEPTH];
    logic [KEY_BITS-1:0] r_key  [DEPTH];
    logic                r_wp, r_rp;
    logic [1:0]          r_cnt;
    logic                w_wr, w_rd;

    assign o_full  = (r_cnt == 2'(DEPTH));
    assign o_valid = (r_cnt != 2'd0);
    assign o_func  = r_func[r_rp];
    assign o_key   = r_key[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_func[r_wp] <= imh_pkg::t_func'(i_func);
            r_key[r_wp]  <= i_key;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) r_wp <= ~r_wp;
            if (w_rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_wr) - 2'(w_rd);
        end
    end

endmodule

/* hw/rtl/imh_back.sv */
// back end: heap engine with heap store, position index and presence bits
module imh_back #(
    parameter int CAPACITY = 64,
    parameter int KEY_BITS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  imh_pkg::t_func                i_func,
    input  logic [KEY_BITS-1:0]           i_key,
    output logic                          o_take,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output logic [imh_pkg::STATUS_BITS-1:0] o_status,
    output logic [KEY_BITS-1:0]           o_popped_key,
    output logic                          o_found,
    output logic [$clog2(CAPACITY+1)-1:0] o_count,
    output logic [KEY_BITS-1:0]           o_top_key,
    output logic                          o_top_valid
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY+1);
    localparam int SPAN = 1 << KEY_BITS;

    imh_pkg::t_state r_state, n_state;

    // presence bits are cleared by a sweep after reset
    logic [KEY_BITS:0]   r_clr;
    logic [CW-1:0]       r_count, n_count;
    imh_pkg::t_func      r_func;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [AW-1:0]       r_p, n_p;
    logic [AW-1:0]       r_c, n_c;
    logic [KEY_BITS-1:0] r_pk, n_pk;        // key at current position
    logic [KEY_BITS-1:0] r_lk, n_lk;        // larger child key
    logic                r_down_after, n_down_after;
    logic [imh_pkg::STATUS_BITS-1:0] r_status, n_status;
    logic [KEY_BITS-1:0] r_popped, n_popped;
    logic                r_found, n_found;
    logic [KEY_BITS-1:0] r_top, n_top;

    // heap store ports
    logic                h_we;
    logic [AW-1:0]       h_wa, h_ra;
    logic [KEY_BITS-1:0] h_wd, h_rd;
    // position index ports
    logic                q_we;
    logic [KEY_BITS-1:0] q_wa, q_ra;
    logic [AW-1:0]       q_wd, q_rd;
    // presence ports
    logic                k_we;
    logic [KEY_BITS-1:0] k_wa, k_ra;
    logic                k_wd, k_rd;

    imh_ram #(.WIDTH(KEY_BITS), .DEPTH(CAPACITY)) u_heap (
        .i_clk, .i_we(h_we), .i_waddr(h_wa), .i_wdata(h_wd), .i_raddr(h_ra), .o_rdata(h_rd));
    imh_ram #(.WIDTH(AW), .DEPTH(SPAN)) u_pos (
        .i_clk, .i_we(q_we), .i_waddr(q_wa), .i_wdata(q_wd), .i_raddr(q_ra), .o_rdata(q_rd));
    imh_ram #(.WIDTH(1), .DEPTH(SPAN)) u_pres (
        .i_clk, .i_we(k_we), .i_waddr(k_wa), .i_wdata(k_wd), .i_raddr(k_ra), .o_rdata(k_rd));

    function automatic logic sgt(input logic [KEY_BITS-1:0] a, input logic [KEY_BITS-1:0] b);
        sgt = $signed(a) > $signed(b);
    endfunction

    assign o_res_valid  = (r_state == imh_pkg::S_DONE);
    assign o_status     = r_status;
    assign o_popped_key = r_popped;
    assign o_found      = r_found;
    assign o_count      = r_count;
    assign o_top_key    = r_top;
    assign o_top_valid  = (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= imh_pkg::S_CLEAR;
            r_clr   <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (r_state == imh_pkg::S_CLEAR) r_clr <= r_clr + 1'b1;
        end
        r_key        <= n_key;
        r_p          <= n_p;
        r_c          <= n_c;
        r_pk         <= n_pk;
        r_lk         <= n_lk;
        r_down_after <= n_down_after;
        r_status     <= n_status;
        r_popped     <= n_popped;
        r_found      <= n_found;
        r_top        <= n_top;
        if (o_take) r_func <= i_func;
    end

    always_comb begin
        logic [AW:0] l, rr;
        logic [AW-1:0] last;
        n_state = r_state;
        n_count = r_count;
        n_key = r_key; n_p = r_p; n_c = r_c; n_pk = r_pk; n_lk = r_lk;
        n_down_after = r_down_after;
        n_status = r_status; n_popped = r_popped; n_found = r_found; n_top = r_top;
        o_take = 1'b0;
        h_we = 1'b0; h_wa = r_p; h_wd = r_pk; h_ra = r_p;
        q_we = 1'b0; q_wa = r_pk; q_wd = r_p; q_ra = r_key;
        k_we = 1'b0; k_wa = r_key; k_wd = 1'b0; k_ra = r_key;
        last = AW'(r_count - 1'b1);
        l  = {r_p, 1'b1};
        rr = l + 1'b1;
        unique case (r_state)
            imh_pkg::S_CLEAR: begin
                k_we = 1'b1;
                k_wa = r_clr[KEY_BITS-1:0];
                if (r_clr == (KEY_BITS+1)'(SPAN - 1)) n_state = imh_pkg::S_IDLE;
            end
            imh_pkg::S_IDLE: begin
                o_take = i_valid;
                if (i_valid) begin
                    n_key = i_key;
                    n_state = imh_pkg::S_LOOKUP;
                end
            end
            imh_pkg::S_LOOKUP: begin
                k_ra = r_key; q_ra = r_key;
                n_state = imh_pkg::S_DECIDE;
            end
            imh_pkg::S_DECIDE: begin
                n_status = imh_pkg::ST_OK;
                n_popped = '0;
                n_found  = 1'b0;
                n_down_after = 1'b0;
                n_state = imh_pkg::S_TOP_RD;
                unique case (r_func)
                    imh_pkg::FN_PUSH: begin
                        if (k_rd) n_status = imh_pkg::ST_DUPLICATE;
                        else if (r_count == CW'(CAPACITY)) n_status = imh_pkg::ST_FULL;
                        else begin
                            h_we = 1'b1; h_wa = AW'(r_count); h_wd = r_key;
                            q_we = 1'b1; q_wa = r_key; q_wd = AW'(r_count);
                            k_we = 1'b1; k_wa = r_key; k_wd = 1'b1;
                            n_count = r_count + 1'b1;
                            n_p  = AW'(r_count);
                            n_pk = r_key;
                            n_state = imh_pkg::S_UP_RD;
                        end
                    end
                    imh_pkg::FN_POP: begin
                        if (r_count == '0) n_status = imh_pkg::ST_EMPTY;
                        else begin
                            // read root then last
                            n_p = '0;
                            n_c = last;
                            n_state = imh_pkg::S_MOVE;
                        end
                    end
                    imh_pkg::FN_REMOVE: begin
                        if (r_count == '0) n_status = imh_pkg::ST_EMPTY;
                        else if (!k_rd) n_status = imh_pkg::ST_ABSENT;
                        else begin
                            k_we = 1'b1; k_wa = r_key; k_wd = 1'b0;
                            n_p = (CW'(q_rd) >= r_count) ? last : q_rd;
                            n_c = last;
                            n_state = imh_pkg::S_MOVE;
                        end
                    end
                    imh_pkg::FN_CONTAINS: begin
                        n_found = k_rd;
                    end
                endcase
                if (n_state == imh_pkg::S_MOVE) h_ra = '0;
            end
            imh_pkg::S_MOVE: begin
                // h_rd holds the root; fetch the last entry next
                h_ra = r_c;
                n_count = r_count - 1'b1;
                n_down_after = (r_func == imh_pkg::FN_REMOVE);
                if (r_func == imh_pkg::FN_POP) begin
                    n_popped = h_rd;
                    k_we = 1'b1; k_wa = h_rd; k_wd = 1'b0;
                end
                // hole in the last slot: the entry is just dropped
                if (r_p == r_c) n_state = imh_pkg::S_TOP_RD;
                else n_state = imh_pkg::S_DN_RD2;
            end
            imh_pkg::S_DN_RD2: begin
                // h_rd holds the moved (last) entry: place it at the hole
                h_we = 1'b1; h_wa = r_p; h_wd = h_rd;
                q_we = 1'b1; q_wa = h_rd; q_wd = r_p;
                n_pk = h_rd;
                n_state = r_down_after ? imh_pkg::S_UP_RD : imh_pkg::S_DN_RD;
            end
            imh_pkg::S_UP_RD: begin
                h_ra = AW'((r_p - 1'b1) >> 1);
                if (r_p == '0) begin
                    h_we = 1'b1; h_wa = r_p; h_wd = r_pk;
                    q_we = 1'b1; q_wa = r_pk; q_wd = r_p;
                    n_state = r_down_after ? imh_pkg::S_DN_RD : imh_pkg::S_TOP_RD;
                end else n_state = imh_pkg::S_UP_CMP;
            end
            imh_pkg::S_UP_CMP: begin
                n_c = AW'((r_p - 1'b1) >> 1);
                if (sgt(r_pk, h_rd)) begin
                    h_we = 1'b1; h_wa = r_p; h_wd = h_rd;
                    q_we = 1'b1; q_wa = h_rd; q_wd = r_p;
                    n_p = n_c;
                    n_state = imh_pkg::S_UP_RD;
                end else begin
                    h_we = 1'b1; h_wa = r_p; h_wd = r_pk;
                    q_we = 1'b1; q_wa = r_pk; q_wd = r_p;
                    n_state = r_down_after ? imh_pkg::S_DN_RD : imh_pkg::S_TOP_RD;
                end
            end
            imh_pkg::S_DN_RD: begin
                n_down_after = 1'b0;
                if (l >= (AW+1)'(r_count)) begin
                    // no child left: settle the moving key here
                    h_we = 1'b1; h_wa = r_p; h_wd = r_pk;
                    q_we = 1'b1; q_wa = r_pk; q_wd = r_p;
                    n_state = imh_pkg::S_TOP_RD;
                end else begin
                    h_ra = l[AW-1:0];
                    n_state = imh_pkg::S_LOOKUP_CHILD;
                end
            end
            imh_pkg::S_LOOKUP_CHILD: begin
                n_lk = h_rd;
                if (rr >= (AW+1)'(r_count)) begin
                    n_c = l[AW-1:0];
                    n_state = imh_pkg::S_DN_CMP;
                end else begin
                    h_ra = rr[AW-1:0];
                    n_state = imh_pkg::S_RIGHT;
                end
            end
            imh_pkg::S_RIGHT: begin
                if (sgt(h_rd, r_lk)) begin
                    n_lk = h_rd; n_c = rr[AW-1:0];
                end else begin
                    n_c = l[AW-1:0];
                end
                n_state = imh_pkg::S_DN_CMP;
            end
            imh_pkg::S_DN_CMP: begin
                if (sgt(r_lk, r_pk)) begin
                    h_we = 1'b1; h_wa = r_p; h_wd = r_lk;
                    q_we = 1'b1; q_wa = r_lk; q_wd = r_p;
                    n_p = r_c;
                    n_state = imh_pkg::S_DN_RD;
                end else begin
                    h_we = 1'b1; h_wa = r_p; h_wd = r_pk;
                    q_we = 1'b1; q_wa = r_pk; q_wd = r_p;
                    n_state = imh_pkg::S_TOP_RD;
                end
            end
            imh_pkg::S_TOP_RD: begin
                h_ra = '0;
                n_state = imh_pkg::S_TOP_WAIT;
            end
            imh_pkg::S_TOP_WAIT: begin
                n_top = (r_count != '0) ? h_rd : '0;
                n_state = imh_pkg::S_DONE;
            end
            imh_pkg::S_DONE: begin
                if (i_res_ready) n_state = imh_pkg::S_IDLE;
            end
            default: n_state = imh_pkg::S_IDLE;
        endcase
    end

endmodule

/* hw/rtl/indexed_max_heap_unit.sv */
// top level of the indexed max-heap unit
//
// usage: a queue-like request channel (i_push / o_full with i_func, i_key)
// and a queue-like result channel (o_empty / i_pop with the result fields).
// every request gives exactly one result, in request order.
// requests: push a key, pop the largest key, remove a named key, or ask
// whether a key is held; status flags duplicate, full, empty and absent keys.
// a two-entry request queue decouples the input from the heap engine, and the
// result is held in an output register until popped.
// timing: a query or rejected request only reads the new top before its
// result; a push also sifts the new key up level by level; a pop or remove
// moves the last entry into the hole and sifts it down (a remove sifts it up
// first), level by level; the sift loop over the single-read heap memory
// sets the time a request takes.
// throughput: one request at a time; the next one starts the cycle after the
// result is popped.
// reset: the key-presence memory is swept to zero, one key per cycle, after
// reset; requests queue up but are not started until the sweep ends.
// when the receiver stalls, the engine holds its result and the request
// queue fills, after which o_full stays high.
module indexed_max_heap_unit #(
    parameter int CAPACITY = 64,
    parameter int KEY_BITS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic [1:0]                    i_func,
    input  logic signed [KEY_BITS-1:0]    i_key,
    output logic                          o_empty,
    input  logic                          i_pop,
    output logic [2:0]                    o_status,
    output logic signed [KEY_BITS-1:0]    o_popped_key,
    output logic                          o_found,
    output logic [$clog2(CAPACITY+1)-1:0] o_count,
    output logic signed [KEY_BITS-1:0]    o_top_key,
    output logic                          o_top_valid
);

    logic                w_valid, w_take, w_res_valid;
    imh_pkg::t_func      w_func;
    logic [KEY_BITS-1:0] w_key;

    // request queue
    imh_front #(.KEY_BITS(KEY_BITS)) u_front (
        .i_clk, .i_rst_n, .i_push, .o_full, .i_func, .i_key,
        .o_valid(w_valid), .o_func(w_func), .o_key(w_key), .i_take(w_take));

    // heap engine with result register
    imh_back #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS)) u_back (
        .i_clk, .i_rst_n, .i_valid(w_valid), .i_func(w_func), .i_key(w_key),
        .o_take(w_take), .o_res_valid(w_res_valid), .i_res_ready(i_pop),
        .o_status, .o_popped_key, .o_found, .o_count, .o_top_key, .o_top_valid);

    assign o_empty = !w_res_valid;

endmodule

/* tb/imh_checker.sv */
// checker for the indexed max-heap unit: predicts each result and compares
`timescale 1ns / 100ps

module imh_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic              i_full,
    input  logic [1:0]        i_func,
    input  logic signed [7:0] i_key,
    input  logic              i_empty,
    input  logic              i_pop,
    input  logic [2:0]        i_status,
    input  logic signed [7:0] i_popped_key,
    input  logic              i_found,
    input  logic [6:0]        i_count,
    input  logic signed [7:0] i_top_key,
    input  logic              i_top_valid,
    output int                o_fail_count,
    output int                o_pending
);

    typedef struct packed {
        logic [2:0]        status;
        logic signed [7:0] popped_key;
        logic              found;
        logic [6:0]        count;
        logic signed [7:0] top_key;
        logic              top_valid;
    } t_heap_result;

    logic signed [7:0] heap_keys [64];
    logic [5:0]        slot_of [256];
    logic              held [256];
    int                num_held;
    t_heap_result      heap_results_due [$];

    // table index of a key, as its raw bits
    function automatic logic [7:0] key_idx(logic signed [7:0] k);
        return k;
    endfunction

    function automatic void swap_slots(int a, int b);
        logic signed [7:0] ka;
        logic signed [7:0] kb;
        ka = heap_keys[a];
        kb = heap_keys[b];
        heap_keys[a] = kb;
        heap_keys[b] = ka;
        slot_of[key_idx(ka)] = 6'(b);
        slot_of[key_idx(kb)] = 6'(a);
    endfunction

    function automatic void sift_up(int p);
        int parent;
        while (p > 0) begin
            parent = (p - 1) / 2;
            if (!(heap_keys[p] > heap_keys[parent])) break;
            swap_slots(p, parent);
            p = parent;
        end
    endfunction

    function automatic void sift_down(int p);
        int l;
        int best;
        forever begin
            l = 2 * p + 1;
            if (l >= num_held) break;
            best = l;
            if (l + 1 < num_held && heap_keys[l + 1] > heap_keys[l]) best = l + 1;
            if (!(heap_keys[best] > heap_keys[p])) break;
            swap_slots(p, best);
            p = best;
        end
    endfunction

    function automatic t_heap_result apply_request(imh_pkg::t_func fn, logic signed [7:0] k);
        t_heap_result r;
        int last;
        int hole;
        logic signed [7:0] moved;
        r = '0;
        r.status = imh_pkg::ST_OK;
        case (fn)
            imh_pkg::FN_PUSH: begin
                if (held[key_idx(k)]) r.status = imh_pkg::ST_DUPLICATE;
                else if (num_held >= 64) r.status = imh_pkg::ST_FULL;
                else begin
                    heap_keys[num_held] = k;
                    slot_of[key_idx(k)] = 6'(num_held);
                    held[key_idx(k)] = 1'b1;
                    num_held++;
                    sift_up(num_held - 1);
                end
            end
            imh_pkg::FN_POP: begin
                if (num_held == 0) r.status = imh_pkg::ST_EMPTY;
                else begin
                    last = num_held - 1;
                    r.popped_key = heap_keys[0];
                    swap_slots(0, last);
                    held[key_idx(r.popped_key)] = 1'b0;
                    num_held = last;
                    sift_down(0);
                end
            end
            imh_pkg::FN_REMOVE: begin
                if (num_held == 0) r.status = imh_pkg::ST_EMPTY;
                else if (!held[key_idx(k)]) r.status = imh_pkg::ST_ABSENT;
                else begin
                    last = num_held - 1;
                    hole = slot_of[key_idx(k)];
                    if (hole >= num_held) hole = last;
                    moved = heap_keys[last];
                    held[key_idx(k)] = 1'b0;
                    num_held = last;
                    if (hole != last) begin
                        heap_keys[hole] = moved;
                        slot_of[key_idx(moved)] = 6'(hole);
                        sift_up(hole);
                        sift_down(slot_of[key_idx(moved)]);
                    end
                end
            end
            default: r.found = held[key_idx(k)];
        endcase
        r.count = 7'(num_held);
        if (num_held > 0) begin
            r.top_key = heap_keys[0];
            r.top_valid = 1'b1;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_heap_result want;
        if (!i_rst_n) begin
            num_held = 0;
            foreach (held[i]) held[i] = 1'b0;
            heap_results_due.delete();
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            if (i_push && !i_full)
                heap_results_due.insert(heap_results_due.size(),
                                        apply_request(imh_pkg::t_func'(i_func), i_key));
            if (i_pop && !i_empty) begin
                if (heap_results_due.size() == 0) begin
                    $error("result with no request waiting");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = heap_results_due.pop_front();
                    if (want != {i_status, i_popped_key, i_found, i_count, i_top_key,
                                 i_top_valid}) begin
                        o_fail_count <= o_fail_count + 1;
                        if (want.status != i_status)
                            $error("status exp %0d got %0d", want.status, i_status);
                        if (want.popped_key != i_popped_key)
                            $error("popped_key exp %0d got %0d", want.popped_key, i_popped_key);
                        if (want.found != i_found)
                            $error("found exp %0d got %0d", want.found, i_found);
                        if (want.count != i_count)
                            $error("count exp %0d got %0d", want.count, i_count);
                        if (want.top_key != i_top_key)
                            $error("top_key exp %0d got %0d", want.top_key, i_top_key);
                        if (want.top_valid != i_top_valid)
                            $error("top_valid exp %0d got %0d", want.top_valid, i_top_valid);
                    end
                end
            end
            o_pending <= heap_results_due.size();
        end
    end

endmodule

/* tb/tb.sv */
// testbench top: drives requests into the heap unit and gives the verdict
`timescale 1ns / 100ps

module tb;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_push;
    logic              o_full;
    logic [1:0]        i_func;
    logic signed [7:0] i_key;
    logic              o_empty;
    logic              i_pop;
    logic [2:0]        o_status;
    logic signed [7:0] o_popped_key;
    logic              o_found;
    logic [6:0]        o_count;
    logic signed [7:0] o_top_key;
    logic              o_top_valid;
    int                fail_count;
    int                results_owed;
    bit                requests_done;

    indexed_max_heap_unit #(.CAPACITY(64), .KEY_BITS(8)) dut (.*);

    imh_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_push), .i_full(o_full),
        .i_func(i_func), .i_key(i_key), .i_empty(o_empty), .i_pop(i_pop),
        .i_status(o_status), .i_popped_key(o_popped_key), .i_found(o_found),
        .i_count(o_count), .i_top_key(o_top_key), .i_top_valid(o_top_valid),
        .o_fail_count(fail_count), .o_pending(results_owed)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hand one request over; waits out the full flag
    task automatic send_request(imh_pkg::t_func fn, logic signed [7:0] k, bit hurry);
        int gap;
        gap = hurry ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_push <= 1'b1;
        i_func <= fn;
        i_key  <= k;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
    endtask

    // key drawn from a small pool most of the time so removes and duplicates hit
    function automatic logic signed [7:0] pick_key(bit narrow);
        if (narrow) return 8'($signed($urandom_range(0, 79)) - 40);
        return 8'($urandom);
    endfunction

    // stimulus
    initial begin
        int phase_mode;
        bit burst;
        imh_pkg::t_func fn;
        int r;
        i_rst_n = 1'b0;
        i_push  = 1'b0;
        i_func  = imh_pkg::FN_PUSH;
        i_key   = '0;
        requests_done = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty-heap cases, key extremes, duplicate, remove paths
        send_request(imh_pkg::FN_POP, 8'sd0, 1'b0);
        send_request(imh_pkg::FN_REMOVE, 8'sd5, 1'b0);
        send_request(imh_pkg::FN_CONTAINS, -8'sd128, 1'b0);
        send_request(imh_pkg::FN_PUSH, -8'sd128, 1'b0);
        send_request(imh_pkg::FN_PUSH, 8'sd127, 1'b0);
        send_request(imh_pkg::FN_PUSH, 8'sd0, 1'b0);
        send_request(imh_pkg::FN_PUSH, -8'sd1, 1'b0);
        send_request(imh_pkg::FN_PUSH, 8'sd127, 1'b0);
        send_request(imh_pkg::FN_CONTAINS, 8'sd127, 1'b0);
        send_request(imh_pkg::FN_CONTAINS, 8'sd1, 1'b0);
        send_request(imh_pkg::FN_REMOVE, 8'sd1, 1'b0);
        send_request(imh_pkg::FN_REMOVE, 8'sd0, 1'b0);
        send_request(imh_pkg::FN_REMOVE, -8'sd128, 1'b0);
        send_request(imh_pkg::FN_PUSH, 8'sd85, 1'b0);
        send_request(imh_pkg::FN_PUSH, -8'sd86, 1'b0);
        send_request(imh_pkg::FN_REMOVE, 8'sd127, 1'b0);
        send_request(imh_pkg::FN_POP, 8'sd0, 1'b0);
        send_request(imh_pkg::FN_POP, 8'sd0, 1'b0);
        send_request(imh_pkg::FN_POP, 8'sd0, 1'b0);
        send_request(imh_pkg::FN_POP, 8'sd0, 1'b0);

        // random phases: fill toward full, drain, and balanced churn
        for (int n = 0; n < 1200; n++) begin
            if (n % 100 == 0) begin
                phase_mode = $urandom_range(0, 2);
                burst = $urandom_range(0, 3) == 0;
            end
            r = $urandom_range(0, 99);
            case (phase_mode)
                0: fn = r < 70 ? imh_pkg::FN_PUSH : r < 80 ? imh_pkg::FN_POP :
                        r < 90 ? imh_pkg::FN_REMOVE : imh_pkg::FN_CONTAINS;
                1: fn = r < 20 ? imh_pkg::FN_PUSH : r < 55 ? imh_pkg::FN_POP :
                        r < 85 ? imh_pkg::FN_REMOVE : imh_pkg::FN_CONTAINS;
                default: fn = imh_pkg::t_func'(r[1:0]);
            endcase
            send_request(fn, pick_key($urandom_range(0, 3) != 0), burst);
        end
        i_push <= 1'b0;
        requests_done = 1'b1;
    end

    // result side with random stalls and stall-free stretches
    initial begin
        int stall;
        i_pop = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                i_pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_pop <= 1'b1;
            @(posedge i_clk);
            while (o_empty) @(posedge i_clk);
        end
    end

    // end of run
    initial begin
        wait (requests_done);
        @(posedge i_clk);
        while (results_owed != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (fail_count == 0 && results_owed == 0)
            $display("[indexed_max_heap_unit] OK");
        else
            $display("[indexed_max_heap_unit] ERROR");
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("[indexed_max_heap_unit] ERROR");
        $finish;
    end

endmodule

/* indexed_max_heap_unit.f */
hw/rtl/imh_pkg.sv
hw/rtl/imh_ram.sv
hw/rtl/imh_front.sv
hw/rtl/imh_back.sv
hw/rtl/indexed_max_heap_unit.sv
tb/imh_checker.sv
tb/tb.sv
